[hw/rtl/shtr_pkg.sv]
// ----------------------------------------------------------------------------
// shtr_pkg
// Shared types and constants of the symbol hash table resolver.
// ----------------------------------------------------------------------------
package shtr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int HASH_W      = 32;
  localparam int ADDR_W      = 32;
  localparam int CHAR_W      = 8;
  localparam int HASH_SHIFT  = 5;
  localparam int ENTRY_W     = HASH_W + ADDR_W;
  localparam int JOB_DEPTH   = 2;
  localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W   = $clog2(JOB_DEPTH + 1);

  localparam logic [HASH_W-1:0] HASH_SEED         = 32'h0000_1505;
  localparam logic [ADDR_W-1:0] NOT_FOUND_ADDRESS = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CHAR = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PROBE,
    BK_CMP,
    BK_FINAL,
    BK_RESULT
  } back_state_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } ram_wr_t;

endpackage

[hw/rtl/shtr_ram.sv]
// ----------------------------------------------------------------------------
// shtr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module shtr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/shtr_front.sv]
// ----------------------------------------------------------------------------
// shtr_front
// Input stage: hashes name characters, writes table entries, queues lookups.
// ----------------------------------------------------------------------------
module shtr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  logic [shtr_pkg::IDX_W-1:0]          entry_index,
  input  logic [shtr_pkg::HASH_W-1:0]         entry_hash,
  input  logic [shtr_pkg::ADDR_W-1:0]         entry_address,
  input  logic [shtr_pkg::CHAR_W-1:0]         name_char,
  input  logic                                name_last,
  input  logic                                lookup_busy,
  input  logic                                job_full,
  output logic                                job_push,
  output logic [shtr_pkg::HASH_W-1:0]         job_key,
  output shtr_pkg::ram_wr_t                   ram_wr
);

  logic                          slot_valid;
  logic                          slot_op;
  logic [shtr_pkg::IDX_W-1:0]    slot_idx;
  logic [shtr_pkg::HASH_W-1:0]   slot_ehash;
  logic [shtr_pkg::ADDR_W-1:0]   slot_eaddr;
  logic [shtr_pkg::CHAR_W-1:0]   slot_char;
  logic                          slot_last;
  logic [shtr_pkg::HASH_W-1:0]   running_hash;
  logic [shtr_pkg::HASH_W-1:0]   hash_next;
  logic                          go;
  logic                          accept;
  logic                          is_char;

  assign is_char   = (slot_op == shtr_pkg::OP_CHAR);
  assign hash_next = (running_hash << shtr_pkg::HASH_SHIFT) + running_hash
                   + {{(shtr_pkg::HASH_W - shtr_pkg::CHAR_W){1'b0}}, slot_char};

  // loads wait until no lookup reads the table
  always_comb begin
    if (is_char) begin
      go = !slot_last || !job_full;
    end else begin
      go = !lookup_busy;
    end
  end

  assign full   = slot_valid && !go;
  assign accept = push && !full;

  assign job_push = slot_valid && go && is_char && slot_last;
  assign job_key  = hash_next;

  assign ram_wr.en   = slot_valid && go && !is_char
                     && ({1'b0, slot_idx} < shtr_pkg::COUNT_W'(shtr_pkg::TABLE_DEPTH));
  assign ram_wr.addr = slot_idx;
  assign ram_wr.data = {slot_ehash, slot_eaddr};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= 1'b0;
      running_hash <= shtr_pkg::HASH_SEED;
    end else begin
      if (accept) begin
        slot_valid <= 1'b1;
      end else if (go) begin
        slot_valid <= 1'b0;
      end
      if (slot_valid && go && is_char) begin
        running_hash <= slot_last ? shtr_pkg::HASH_SEED : hash_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_op    <= operation;
      slot_idx   <= entry_index;
      slot_ehash <= entry_hash;
      slot_eaddr <= entry_address;
      slot_char  <= name_char;
      slot_last  <= name_last;
    end
  end

endmodule

[hw/rtl/shtr_job_fifo.sv]
// ----------------------------------------------------------------------------
// shtr_job_fifo
// Short queue of lookup keys between the front and back parts.
// ----------------------------------------------------------------------------
module shtr_job_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [shtr_pkg::HASH_W-1:0] wr_data,
  output logic                        q_full,
  input  logic                        rd_en,
  output logic [shtr_pkg::HASH_W-1:0] rd_data,
  output logic                        q_empty
);

  logic [shtr_pkg::HASH_W-1:0]    entries [shtr_pkg::JOB_DEPTH];
  logic [shtr_pkg::JOB_PTR_W-1:0] wptr;
  logic [shtr_pkg::JOB_PTR_W-1:0] rptr;
  logic [shtr_pkg::JOB_CNT_W-1:0] count;
  logic                           do_wr;
  logic                           do_rd;

  assign q_full  = (count == shtr_pkg::JOB_CNT_W'(shtr_pkg::JOB_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == shtr_pkg::JOB_PTR_W'(shtr_pkg::JOB_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == shtr_pkg::JOB_PTR_W'(shtr_pkg::JOB_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

[hw/rtl/shtr_back.sv]
// ----------------------------------------------------------------------------
// shtr_back
// Lookup engine: lower-bound binary search over the table, result register.
// ----------------------------------------------------------------------------
module shtr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [shtr_pkg::COUNT_W-1:0]        entry_count,
  input  logic                                job_empty,
  input  logic [shtr_pkg::HASH_W-1:0]         job_key,
  output logic                                job_pop,
  output logic                                busy,
  output logic [shtr_pkg::IDX_W-1:0]          ram_raddr,
  input  logic [shtr_pkg::ENTRY_W-1:0]        ram_rdata,
  output logic                                empty,
  input  logic                                pop,
  output logic                                found,
  output logic [shtr_pkg::ADDR_W-1:0]         symbol_address,
  output logic [shtr_pkg::HASH_W-1:0]         name_hash
);

  shtr_pkg::back_state_t          state, state_next;
  logic [shtr_pkg::COUNT_W-1:0]   first, first_next;
  logic [shtr_pkg::COUNT_W-1:0]   len, len_next;
  logic [shtr_pkg::COUNT_W-1:0]   limit, limit_next;
  logic [shtr_pkg::COUNT_W-1:0]   probe, probe_next;
  logic [shtr_pkg::COUNT_W-1:0]   step;
  logic [shtr_pkg::COUNT_W-1:0]   clamped;
  logic [shtr_pkg::HASH_W-1:0]    key, key_next;
  logic                           res_found, res_found_next;
  logic [shtr_pkg::ADDR_W-1:0]    res_addr, res_addr_next;
  logic                           out_valid;
  logic                           out_load;
  logic [shtr_pkg::HASH_W-1:0]    rd_hash;
  logic [shtr_pkg::ADDR_W-1:0]    rd_addr;

  assign rd_hash = ram_rdata[shtr_pkg::ENTRY_W-1 -: shtr_pkg::HASH_W];
  assign rd_addr = ram_rdata[shtr_pkg::ADDR_W-1:0];
  assign step    = len >> 1;
  assign clamped = (entry_count > shtr_pkg::COUNT_W'(shtr_pkg::TABLE_DEPTH))
                 ? shtr_pkg::COUNT_W'(shtr_pkg::TABLE_DEPTH) : entry_count;
  assign busy    = (state != shtr_pkg::BK_IDLE);
  assign empty   = !out_valid;

  always_comb begin
    state_next     = state;
    first_next     = first;
    len_next       = len;
    limit_next     = limit;
    probe_next     = probe;
    key_next       = key;
    res_found_next = res_found;
    res_addr_next  = res_addr;
    job_pop        = 1'b0;
    out_load       = 1'b0;
    ram_raddr      = probe_next[shtr_pkg::IDX_W-1:0];
    case (state)
      shtr_pkg::BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          key_next   = job_key;
          first_next = '0;
          len_next   = clamped;
          limit_next = clamped;
          state_next = shtr_pkg::BK_PROBE;
        end
      end
      shtr_pkg::BK_PROBE: begin
        if (len == '0) begin
          if (first < limit) begin
            ram_raddr  = first[shtr_pkg::IDX_W-1:0];
            state_next = shtr_pkg::BK_FINAL;
          end else begin
            res_found_next = 1'b0;
            res_addr_next  = shtr_pkg::NOT_FOUND_ADDRESS;
            state_next     = shtr_pkg::BK_RESULT;
          end
        end else begin
          probe_next = first + step;
          ram_raddr  = probe_next[shtr_pkg::IDX_W-1:0];
          state_next = shtr_pkg::BK_CMP;
        end
      end
      shtr_pkg::BK_CMP: begin
        if (rd_hash < key) begin
          first_next = probe + 1'b1;
          len_next   = len - step - 1'b1;
        end else begin
          len_next   = step;
        end
        state_next = shtr_pkg::BK_PROBE;
      end
      shtr_pkg::BK_FINAL: begin
        res_found_next = (rd_hash == key);
        res_addr_next  = (rd_hash == key) ? rd_addr : shtr_pkg::NOT_FOUND_ADDRESS;
        state_next     = shtr_pkg::BK_RESULT;
      end
      shtr_pkg::BK_RESULT: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = shtr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = shtr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shtr_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first     <= first_next;
    len       <= len_next;
    limit     <= limit_next;
    probe     <= probe_next;
    key       <= key_next;
    res_found <= res_found_next;
    res_addr  <= res_addr_next;
    if (out_load) begin
      found          <= res_found;
      symbol_address <= res_addr;
      name_hash      <= key;
    end
  end

endmodule

[hw/rtl/symbol_hash_table_resolver_unit.sv]
// ----------------------------------------------------------------------------
// symbol_hash_table_resolver_unit
// Resolves a hashed symbol name to an address through a sorted table.
// ----------------------------------------------------------------------------
// Characters and table loads are taken one beat a cycle into a one-entry input stage
// while it is not stalled. A lookup makes up to 7 binary search probes for 64 entries,
// each a RAM read then a compare, then a final read if a candidate is left, and the result register.
// A load waits while any lookup is queued or running, since lookups read the table RAM.
// Reset clears the control state, sets the running hash to its seed and entry_count to 0;
// the table RAM is not cleared and holds undefined data until loaded.
module symbol_hash_table_resolver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  logic [shtr_pkg::IDX_W-1:0]          entry_index,
  input  logic [shtr_pkg::HASH_W-1:0]         entry_hash,
  input  logic [shtr_pkg::ADDR_W-1:0]         entry_address,
  input  logic [shtr_pkg::CHAR_W-1:0]         name_char,
  input  logic                                name_last,
  output logic                                empty,
  input  logic                                pop,
  output logic                                found,
  output logic [shtr_pkg::ADDR_W-1:0]         symbol_address,
  output logic [shtr_pkg::HASH_W-1:0]         name_hash,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shtr_pkg::COUNT_W-1:0]        entry_count
);

  logic [shtr_pkg::COUNT_W-1:0]  count_reg;
  logic                          job_full;
  logic                          job_empty;
  logic                          job_push;
  logic                          job_pop;
  logic [shtr_pkg::HASH_W-1:0]   job_wkey;
  logic [shtr_pkg::HASH_W-1:0]   job_rkey;
  logic                          back_busy;
  logic                          lookup_busy;
  shtr_pkg::ram_wr_t             ram_wr;
  logic [shtr_pkg::IDX_W-1:0]    ram_raddr;
  logic [shtr_pkg::ENTRY_W-1:0]  ram_rdata;

  assign cfg_ready   = 1'b1;
  assign lookup_busy = !job_empty || back_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_reg <= entry_count;
    end
  end

  shtr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .entry_index   (entry_index),
    .entry_hash    (entry_hash),
    .entry_address (entry_address),
    .name_char     (name_char),
    .name_last     (name_last),
    .lookup_busy   (lookup_busy),
    .job_full      (job_full),
    .job_push      (job_push),
    .job_key       (job_wkey),
    .ram_wr        (ram_wr)
  );

  shtr_job_fifo u_job_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_wkey),
    .q_full  (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rkey),
    .q_empty (job_empty)
  );

  shtr_ram #(
    .WIDTH (shtr_pkg::ENTRY_W),
    .DEPTH (shtr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  shtr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .entry_count    (count_reg),
    .job_empty      (job_empty),
    .job_key        (job_rkey),
    .job_pop        (job_pop),
    .busy           (back_busy),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .empty          (empty),
    .pop            (pop),
    .found          (found),
    .symbol_address (symbol_address),
    .name_hash      (name_hash)
  );

endmodule

[test/tb_symbol_hash_table_resolver_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_symbol_hash_table_resolver_unit
// Self-checking bench for the symbol hash table resolver. Table loads and name
// characters go in as beats from a queue. A bench-side copy of the hash, the
// table and the entry count computes each lookup's found flag, address and
// hash. Results are compared in order, under random idling on both sides, a
// long receiver hold-off and several entry_count settings, 0, 64 and 127
// among them.
// ----------------------------------------------------------------------------
module tb_symbol_hash_table_resolver_unit;

  localparam int MAX_NAME    = 12;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_BEATS = 128;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_PHASE  = 7;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    shtr_pkg::op_t                   op;
    logic [shtr_pkg::IDX_W-1:0]      idx;
    logic [shtr_pkg::HASH_W-1:0]     key;
    logic [shtr_pkg::ADDR_W-1:0]     addr;
    logic [shtr_pkg::CHAR_W-1:0]     ch;
    logic                            last;
  } beat_t;

  typedef struct {
    logic                            found;
    logic [shtr_pkg::ADDR_W-1:0]     addr;
    logic [shtr_pkg::HASH_W-1:0]     hash;
  } lookup_t;

  logic                              clk;
  logic                              rst;
  logic                              push;
  logic                              full;
  logic                              operation;
  logic [shtr_pkg::IDX_W-1:0]        entry_index;
  logic [shtr_pkg::HASH_W-1:0]       entry_hash;
  logic [shtr_pkg::ADDR_W-1:0]       entry_address;
  logic [shtr_pkg::CHAR_W-1:0]       name_char;
  logic                              name_last;
  logic                              empty;
  logic                              pop;
  logic                              found;
  logic [shtr_pkg::ADDR_W-1:0]       symbol_address;
  logic [shtr_pkg::HASH_W-1:0]       name_hash;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [shtr_pkg::COUNT_W-1:0]      entry_count;

  // stimulus side
  beat_t                             pending_beats[$];
  beat_t                             nxt;
  int                                queued_beats;
  int                                send_idle_pct;
  int                                recv_idle_pct;
  int                                phase_id;
  logic [MAX_NAME-1:0][shtr_pkg::CHAR_W-1:0] slot_chars[shtr_pkg::TABLE_DEPTH];
  int                                slot_len[shtr_pkg::TABLE_DEPTH];
  logic [shtr_pkg::HASH_W-1:0]       slot_key[shtr_pkg::TABLE_DEPTH];

  // predicted block state
  logic [shtr_pkg::HASH_W-1:0]       pred_running;
  logic [shtr_pkg::HASH_W-1:0]       pred_key[shtr_pkg::TABLE_DEPTH];
  logic [shtr_pkg::ADDR_W-1:0]       pred_addr[shtr_pkg::TABLE_DEPTH];
  logic [shtr_pkg::COUNT_W-1:0]      count_setting;
  lookup_t                           expected_lookups[$];
  lookup_t                           want;
  bit                                cfg_pending;

  int                                mismatches;
  int                                beats_accepted;
  int                                loads_accepted;
  int                                lookups_checked;
  int                                hits_checked;
  int                                hold_left;
  bit                                hold_done;
  int                                cycle_count;

  symbol_hash_table_resolver_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .entry_index    (entry_index),
    .entry_hash     (entry_hash),
    .entry_address  (entry_address),
    .name_char      (name_char),
    .name_last      (name_last),
    .empty          (empty),
    .pop            (pop),
    .found          (found),
    .symbol_address (symbol_address),
    .name_hash      (name_hash),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .entry_count    (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [shtr_pkg::HASH_W-1:0] step_hash(
      input logic [shtr_pkg::HASH_W-1:0] h, input logic [shtr_pkg::CHAR_W-1:0] c);
    return (h << shtr_pkg::HASH_SHIFT) + h
         + {{(shtr_pkg::HASH_W-shtr_pkg::CHAR_W){1'b0}}, c};
  endfunction

  function automatic logic [shtr_pkg::HASH_W-1:0] key_of(
      input logic [MAX_NAME-1:0][shtr_pkg::CHAR_W-1:0] chars, input int len);
    logic [shtr_pkg::HASH_W-1:0] h;
    h = shtr_pkg::HASH_SEED;
    for (int i = 0; i < len; i++) h = step_hash(h, chars[i]);
    return h;
  endfunction

  // lower-bound search over the predicted table
  function automatic lookup_t resolve_name(input logic [shtr_pkg::HASH_W-1:0] key);
    int n;
    int first;
    int len;
    int half;
    lookup_t r;
    n = (count_setting > shtr_pkg::TABLE_DEPTH) ? shtr_pkg::TABLE_DEPTH
                                                : int'(count_setting);
    first = 0;
    len = n;
    while (len > 0) begin
      half = len / 2;
      if (pred_key[first + half] < key) begin
        first = first + half + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    r.found = (first < n) && (pred_key[first] == key);
    r.addr  = r.found ? pred_addr[first] : shtr_pkg::NOT_FOUND_ADDRESS;
    r.hash  = key;
    return r;
  endfunction

  // driver, with prediction at acceptance
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pred_running = shtr_pkg::HASH_SEED;
    end else begin
      if (push && !full) begin
        beats_accepted++;
        if (shtr_pkg::op_t'(operation) == shtr_pkg::OP_LOAD) begin
          loads_accepted++;
          pred_key[entry_index]  = entry_hash;
          pred_addr[entry_index] = entry_address;
        end else begin
          pred_running = step_hash(pred_running, name_char);
          if (name_last) begin
            expected_lookups.push_back(resolve_name(pred_running));
            pred_running = shtr_pkg::HASH_SEED;
          end
        end
      end
      if (!push || !full) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          push          <= 1'b1;
          operation     <= nxt.op;
          entry_index   <= nxt.idx;
          entry_hash    <= nxt.key;
          entry_address <= nxt.addr;
          name_char     <= nxt.ch;
          name_last     <= nxt.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_lookups.size() == 0) begin
          $error("result beat with no lookup pending, name_hash %h", name_hash);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          lookups_checked++;
          if (want.found) hits_checked++;
          if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            mismatches++;
          end
          if (symbol_address !== want.addr) begin
            $error("symbol_address: expected %h, actual %h", want.addr, symbol_address);
            mismatches++;
          end
          if (name_hash !== want.hash) begin
            $error("name_hash: expected %h, actual %h", want.hash, name_hash);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (phase_id == HOLD_PHASE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // config write channel
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      count_setting = entry_count;
      cfg_pending = 1'b0;
      cfg_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_load(input int idx, input logic [shtr_pkg::HASH_W-1:0] key,
                           input logic [shtr_pkg::ADDR_W-1:0] addr);
    beat_t b;
    b.op   = shtr_pkg::OP_LOAD;
    b.idx  = idx[shtr_pkg::IDX_W-1:0];
    b.key  = key;
    b.addr = addr;
    b.ch   = shtr_pkg::CHAR_W'($urandom);
    b.last = 1'($urandom);
    pending_beats.push_back(b);
    queued_beats++;
  endtask

  task automatic push_char(input logic [shtr_pkg::CHAR_W-1:0] ch, input logic last);
    beat_t b;
    b.op   = shtr_pkg::OP_CHAR;
    b.idx  = shtr_pkg::IDX_W'($urandom);
    b.key  = $urandom;
    b.addr = $urandom;
    b.ch   = ch;
    b.last = last;
    pending_beats.push_back(b);
    queued_beats++;
  endtask

  // a stray load between characters; the slot no longer names a known symbol
  task automatic push_name(input logic [MAX_NAME-1:0][shtr_pkg::CHAR_W-1:0] chars,
                           input int len);
    int s;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(49) == 0) begin
        s = $urandom_range(shtr_pkg::TABLE_DEPTH-1);
        slot_len[s] = 0;
        push_load(s, $urandom, $urandom);
      end
      push_char(chars[i], i == len - 1);
    end
  endtask

  task automatic make_name(output logic [MAX_NAME-1:0][shtr_pkg::CHAR_W-1:0] chars,
                           output int len);
    len = ($urandom_range(9) == 0) ? $urandom_range(7, MAX_NAME) : $urandom_range(1, 6);
    for (int i = 0; i < MAX_NAME; i++) chars[i] = shtr_pkg::CHAR_W'($urandom_range(1, 255));
  endtask

  // fill all slots with names in ascending hash order, some hashes repeated
  task automatic reload_table();
    logic [MAX_NAME-1:0][shtr_pkg::CHAR_W-1:0] tmp_chars;
    int tmp_len;
    logic [shtr_pkg::HASH_W-1:0] tmp_key;
    for (int s = 0; s < shtr_pkg::TABLE_DEPTH; s++) begin
      if (s > 0 && $urandom_range(9) == 0) begin
        slot_chars[s] = slot_chars[s-1];
        slot_len[s]   = slot_len[s-1];
      end else begin
        make_name(slot_chars[s], slot_len[s]);
      end
      slot_key[s] = key_of(slot_chars[s], slot_len[s]);
    end
    for (int i = 1; i < shtr_pkg::TABLE_DEPTH; i++) begin
      for (int j = i; j > 0 && slot_key[j-1] > slot_key[j]; j--) begin
        tmp_chars = slot_chars[j]; slot_chars[j] = slot_chars[j-1]; slot_chars[j-1] = tmp_chars;
        tmp_len   = slot_len[j];   slot_len[j]   = slot_len[j-1];   slot_len[j-1]   = tmp_len;
        tmp_key   = slot_key[j];   slot_key[j]   = slot_key[j-1];   slot_key[j-1]   = tmp_key;
      end
    end
    if ($urandom_range(3) == 0) begin
      slot_key[0] = '0;
      slot_len[0] = 0;
    end
    if ($urandom_range(3) == 0) begin
      slot_key[shtr_pkg::TABLE_DEPTH-1] = '1;
      slot_len[shtr_pkg::TABLE_DEPTH-1] = 0;
    end
    for (int s = 0; s < shtr_pkg::TABLE_DEPTH; s++) push_load(s, slot_key[s], $urandom);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || push || expected_lookups.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_entry_count(input int value);
    wait_idle();
    @(posedge clk);
    cfg_pending = 1'b1;
    cfg_valid   <= 1'b1;
    entry_count <= value[shtr_pkg::COUNT_W-1:0];
    while (cfg_pending) @(posedge clk);
  endtask

  initial begin
    logic [MAX_NAME-1:0][shtr_pkg::CHAR_W-1:0] chars;
    int len;
    int s;
    int start;
    int phase_counts[NUM_PHASES];
    logic [shtr_pkg::HASH_W-1:0] key_ab;

    phase_counts = '{64, 127, 0, 1, 2, 33, 64, 17, 64, 0};
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    entry_count   <= '0;
    operation     <= shtr_pkg::OP_LOAD;
    entry_index   <= '0;
    entry_hash    <= '0;
    entry_address <= '0;
    name_char     <= '0;
    name_last     <= 1'b0;
    count_setting = '0;
    send_idle_pct = 19;
    recv_idle_pct = 82;
    phase_id      = -1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty search right after reset, then a zero character
    push_char(8'h61, 1'b1);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);
    // four slots: zero hash, a repeated hash, all-ones hash
    key_ab = step_hash(step_hash(shtr_pkg::HASH_SEED, 8'h61), 8'h62);
    push_load(0, '0, '0);
    push_load(1, key_ab, 32'h1111_0001);
    push_load(2, key_ab, 32'h2222_0002);
    push_load(3, '1, '1);
    write_entry_count(4);
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b1);
    push_char(8'h78, 1'b1);
    // load between characters keeps the running hash
    push_char(8'h61, 1'b0);
    push_load(3, '1, 32'hA5A5_5A5A);
    push_char(8'h62, 1'b1);
    push_char(8'h80, 1'b0);
    push_char(8'h7F, 1'b0);
    push_char(8'h01, 1'b1);
    write_entry_count(1);
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b1);
    write_entry_count(2);
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 19;
        recv_idle_pct = 82;
      end else if (p < HOLD_PHASE) begin
        send_idle_pct = 82;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_entry_count((p == NUM_PHASES - 1) ? $urandom_range(0, shtr_pkg::TABLE_DEPTH)
                                              : phase_counts[p]);
      phase_id = p;
      if (p % 2 == 0) reload_table();
      start = queued_beats;
      while (queued_beats - start < PHASE_BEATS) begin
        s = $urandom_range(shtr_pkg::TABLE_DEPTH-1);
        if ($urandom_range(99) < 60 && slot_len[s] != 0) begin
          push_name(slot_chars[s], slot_len[s]);
        end else begin
          make_name(chars, len);
          push_name(chars, len);
        end
      end
    end
    wait_idle();

    $display("%0d beats in (%0d table loads), %0d lookups checked, %0d of them hits",
             beats_accepted, loads_accepted, lookups_checked, hits_checked);
    $display("entry_count from 0 to 127 over %0d phases, one %0d-cycle receiver hold-off",
             NUM_PHASES, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[symbol_hash_table_resolver_unit.f]
hw/rtl/shtr_pkg.sv
hw/rtl/shtr_ram.sv
hw/rtl/shtr_front.sv
hw/rtl/shtr_job_fifo.sv
hw/rtl/shtr_back.sv
hw/rtl/symbol_hash_table_resolver_unit.sv
test/tb_symbol_hash_table_resolver_unit.sv
